// ===== rtl/max_heap_priority_queue_defines.svh =====
// Assertion macros for the max-heap priority queue.
// Used by the top level; depends on nothing else.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`define MHPQ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MHPQ_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mhpq_pkg.sv =====
// Shared constants and codes for the max-heap priority queue.
// Used by the top level; depends on nothing.
package mhpq_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = 11;
  localparam int POS_W      = 10;
  localparam int KEY_W      = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CHANGE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage

// ===== rtl/mhpq_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// Holds the heap array; depends on nothing.
module mhpq_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a_r,
  output logic [DATA_W-1:0] rdata_b_r
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// Top level of the binary max-heap priority queue: command handling and sift sequencer.
// Depends on mhpq_pkg, mhpq_ram and max_heap_priority_queue_defines.svh.
//
//   channel   ports                                   handshake
//   request   in_mode, in_item_value, in_position     start && !busy
//   result    out_status .. out_entry_count           out_valid, one cycle
//
// Errors and clear give their result in the cycle after the request.
// A sift works level by level: a memory read, then a compare and write back,
// for each level until the key is in place.
// The heap array needs no clearing after reset; only the state, the count and out_valid are reset.
// The result cannot be stalled: it is shown for one cycle while busy is low.
`include "max_heap_priority_queue_defines.svh"

module max_heap_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_item_value,
  input  logic [9:0]  in_position,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_removed_value,
  output logic [31:0] out_top_value,
  output logic        out_top_valid,
  output logic [10:0] out_entry_count
);

  localparam int IW = mhpq_pkg::IDX_W;
  localparam int CW = mhpq_pkg::CNT_W;
  localparam int KW = mhpq_pkg::KEY_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_LAST,
    S_CHG_CMP
  } state_t;

  state_t              state_r, state_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [KW-1:0]       top_r, top_nxt;
  mhpq_pkg::status_t   status_r, status_nxt;
  logic [KW-1:0]       removed_r, removed_nxt;
  logic                fin;

  logic                we;
  logic [IW-1:0]       waddr, ra, rb;
  logic [KW-1:0]       wdata, rdata_a, rdata_b;

  logic [IW-1:0]       parent;
  logic [CW-1:0]       left_w;
  logic [CW:0]         right_w;
  logic                right_ok, pick_right;
  logic [KW-1:0]       pick_val;
  logic [IW-1:0]       pick_idx;
  logic [KW-1:0]       in_key;

  mhpq_ram #(.DATA_W(KW), .ADDR_W(IW)) u_ram (
    .clk       (clk),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr_a   (ra),
    .raddr_b   (rb),
    .rdata_a_r (rdata_a),
    .rdata_b_r (rdata_b)
  );

  assign in_key     = in_item_value[KW-1:0];
  assign parent     = (idx_r - IW'(1)) >> 1;
  assign left_w     = CW'({idx_r, 1'b1});
  assign right_w    = {1'b0, left_w} + (CW+1)'(1);
  assign right_ok   = right_w < {1'b0, cnt_r};
  assign pick_right = right_ok && (rdata_b > rdata_a);
  assign pick_val   = pick_right ? rdata_b : rdata_a;
  assign pick_idx   = pick_right ? right_w[IW-1:0] : left_w[IW-1:0];
  assign top_nxt    = (we && (waddr == '0)) ? wdata : top_r;
  assign busy       = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    fin         = 1'b0;
    we          = 1'b0;
    waddr       = idx_r;
    wdata       = key_r;
    ra          = idx_r;
    rb          = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt  = mhpq_pkg::ST_OK;
          removed_nxt = '0;
          unique case (mhpq_pkg::mode_t'(in_mode))
            mhpq_pkg::MODE_INSERT: begin
              if (cnt_r == CW'(mhpq_pkg::HEAP_DEPTH)) begin
                status_nxt = mhpq_pkg::ST_FULL;
                fin        = 1'b1;
              end else begin
                idx_nxt   = cnt_r[IW-1:0];
                key_nxt   = in_key;
                cnt_nxt   = cnt_r + CW'(1);
                state_nxt = S_UP_RD;
              end
            end
            mhpq_pkg::MODE_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = mhpq_pkg::ST_EMPTY;
                fin        = 1'b1;
              end else begin
                removed_nxt = top_r;
                cnt_nxt     = cnt_r - CW'(1);
                idx_nxt     = '0;
                ra          = cnt_nxt[IW-1:0];
                if (cnt_r == CW'(1)) begin
                  fin = 1'b1;
                end else begin
                  state_nxt = S_LAST;
                end
              end
            end
            mhpq_pkg::MODE_CHANGE: begin
              if (cnt_r == '0) begin
                status_nxt = mhpq_pkg::ST_EMPTY;
                fin        = 1'b1;
              end else if ({1'b0, in_position} >= cnt_r) begin
                status_nxt = mhpq_pkg::ST_BADPOS;
                fin        = 1'b1;
              end else begin
                idx_nxt   = IW'(in_position);
                key_nxt   = in_key;
                ra        = IW'(in_position);
                state_nxt = S_CHG_CMP;
              end
            end
            mhpq_pkg::MODE_CLEAR: begin
              cnt_nxt = '0;
              fin     = 1'b1;
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (idx_r == '0) begin
          we  = 1'b1;
          fin = 1'b1;
        end else begin
          ra        = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (key_r > rdata_a) begin
          wdata     = rdata_a;
          idx_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          fin = 1'b1;
        end
      end
      S_LAST: begin
        key_nxt   = rdata_a;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        if (left_w >= cnt_r) begin
          we  = 1'b1;
          fin = 1'b1;
        end else begin
          ra        = left_w[IW-1:0];
          rb        = right_w[IW-1:0];
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (pick_val > key_r) begin
          wdata     = pick_val;
          idx_nxt   = pick_idx;
          state_nxt = S_DN_RD;
        end else begin
          fin = 1'b1;
        end
      end
      S_CHG_CMP: begin
        if (key_r > rdata_a) begin
          state_nxt = S_UP_RD;
        end else if (key_r < rdata_a) begin
          state_nxt = S_DN_RD;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    key_r     <= key_nxt;
    top_r     <= top_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    if (fin) begin
      out_status        <= status_nxt;
      out_removed_value <= 32'(removed_nxt);
      out_top_value     <= (cnt_nxt != '0) ? 32'(top_nxt) : '0;
      out_top_valid     <= (cnt_nxt != '0);
      out_entry_count   <= cnt_nxt;
    end
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_valid <= fin;
    end
  end

  `MHPQ_ASSERT_IMP(a_write_in_range, we, {1'b0, waddr} < cnt_nxt, "write beyond held entries")
  `MHPQ_ASSERT_NXT(a_accept_progress, start && !busy, out_valid || busy, "request neither done nor busy")
  `MHPQ_ASSERT_IMP(a_top_valid_count, out_valid, out_top_valid == (out_entry_count != '0), "top valid disagrees with count")
  `MHPQ_ASSERT_IMP(a_removed_only_ok, out_valid && (out_status != mhpq_pkg::ST_OK), out_removed_value == '0, "removed value on error")

endmodule

// ===== tb/heap_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the max-heap priority queue: it keeps its own copy of the heap,
// works out the expected report for every accepted request and compares it with the block.
// Depends on mhpq_pkg.
module heap_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_item_value,
  input  logic [9:0]  in_position,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_removed_value,
  input  logic [31:0] out_top_value,
  input  logic        out_top_valid,
  input  logic [10:0] out_entry_count,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    mhpq_pkg::status_t          status;
    logic [mhpq_pkg::KEY_W-1:0] removed;
    logic [mhpq_pkg::KEY_W-1:0] top;
    logic                       top_valid;
    logic [mhpq_pkg::CNT_W-1:0] count;
  } queue_report_t;

  logic [mhpq_pkg::KEY_W-1:0] keys [mhpq_pkg::HEAP_DEPTH];
  int                         held;
  queue_report_t              expected_reports [$];

  function automatic void swap_keys(input int a, input int b);
    logic [mhpq_pkg::KEY_W-1:0] t;
    t       = keys[a];
    keys[a] = keys[b];
    keys[b] = t;
  endfunction

  function automatic void sift_toward_root(input int idx);
    int parent;
    bit moving;
    moving = 1'b1;
    while (moving && idx > 0) begin
      parent = (idx - 1) / 2;
      if (keys[idx] > keys[parent]) begin
        swap_keys(idx, parent);
        idx = parent;
      end else begin
        moving = 1'b0;
      end
    end
  endfunction

  function automatic void sift_toward_leaves(input int idx);
    int  left;
    int  pick;
    bit  moving;
    moving = 1'b1;
    while (moving && 2 * idx + 1 < held) begin
      left = 2 * idx + 1;
      pick = left;
      if (left + 1 < held && keys[left + 1] > keys[left]) begin
        pick = left + 1;
      end
      if (keys[pick] > keys[idx]) begin
        swap_keys(idx, pick);
        idx = pick;
      end else begin
        moving = 1'b0;
      end
    end
  endfunction

  function automatic queue_report_t predict_report(input mhpq_pkg::mode_t mode,
                                                   input logic [mhpq_pkg::KEY_W-1:0] key,
                                                   input logic [mhpq_pkg::POS_W-1:0] pos);
    queue_report_t              r;
    logic [mhpq_pkg::KEY_W-1:0] old_key;
    r.status  = mhpq_pkg::ST_OK;
    r.removed = '0;
    case (mode)
      mhpq_pkg::MODE_INSERT: begin
        if (held >= mhpq_pkg::HEAP_DEPTH) begin
          r.status = mhpq_pkg::ST_FULL;
        end else begin
          keys[held] = key;
          held++;
          sift_toward_root(held - 1);
        end
      end
      mhpq_pkg::MODE_REMOVE: begin
        if (held == 0) begin
          r.status = mhpq_pkg::ST_EMPTY;
        end else begin
          r.removed = keys[0];
          held--;
          if (held > 0) begin
            keys[0] = keys[held];
            sift_toward_leaves(0);
          end
        end
      end
      mhpq_pkg::MODE_CHANGE: begin
        if (held == 0) begin
          r.status = mhpq_pkg::ST_EMPTY;
        end else if (int'(pos) >= held) begin
          r.status = mhpq_pkg::ST_BADPOS;
        end else begin
          old_key   = keys[pos];
          keys[pos] = key;
          if (key > old_key) begin
            sift_toward_root(int'(pos));
          end else if (key < old_key) begin
            sift_toward_leaves(int'(pos));
          end
        end
      end
      mhpq_pkg::MODE_CLEAR: begin
        held = 0;
      end
    endcase
    r.top       = (held > 0) ? keys[0] : '0;
    r.top_valid = (held > 0);
    r.count     = mhpq_pkg::CNT_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    queue_report_t want;
    if (!rst_n) begin
      held = 0;
      expected_reports.delete();
    end else begin
      if (out_valid) begin
        if (expected_reports.size() == 0) begin
          if (fail_count < 10) begin
            $display("%t: result with no request outstanding: status %0d top %h count %0d",
                     $realtime, out_status, out_top_value, out_entry_count);
          end
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          checked++;
          if (out_status !== want.status || out_removed_value !== want.removed ||
              out_top_value !== want.top || out_top_valid !== want.top_valid ||
              out_entry_count !== want.count) begin
            if (fail_count < 10) begin
              $display("%t: result %0d expected status %0d removed %h top %h valid %0b count %0d",
                       $realtime, checked, want.status, want.removed, want.top,
                       want.top_valid, want.count);
              $display("%t: result %0d got      status %0d removed %h top %h valid %0b count %0d",
                       $realtime, checked, out_status, out_removed_value, out_top_value,
                       out_top_valid, out_entry_count);
            end
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_reports.push_back(predict_report(mhpq_pkg::mode_t'(in_mode), in_item_value,
                                                  in_position));
      end
    end
    pending = expected_reports.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the max-heap priority queue testbench: clock, reset, request stimulus and verdict.
// Depends on mhpq_pkg, max_heap_priority_queue and heap_result_checker.
module tb;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [31:0] in_item_value;
  logic [9:0]  in_position;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_removed_value;
  logic [31:0] out_top_value;
  logic        out_top_valid;
  logic [10:0] out_entry_count;

  int fail_count;
  int pending;
  int checked;

  int fill;
  int peak_fill;
  int requests;
  int full_rejects;
  bit idling_on;

  max_heap_priority_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_item_value     (in_item_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_top_value     (out_top_value),
    .out_top_valid     (out_top_valid),
    .out_entry_count   (out_entry_count)
  );

  heap_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_item_value     (in_item_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_top_value     (out_top_value),
    .out_top_valid     (out_top_valid),
    .out_entry_count   (out_entry_count),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_request(input mhpq_pkg::mode_t m, input logic [31:0] v,
                              input logic [9:0] p);
    @(negedge clk);
    start         <= 1'b1;
    in_mode       <= m;
    in_item_value <= v;
    in_position   <= p;
    do @(posedge clk); while (busy);
    requests++;
    case (m)
      mhpq_pkg::MODE_INSERT: begin
        if (fill == mhpq_pkg::HEAP_DEPTH) begin
          full_rejects++;
        end else begin
          fill++;
        end
      end
      mhpq_pkg::MODE_REMOVE: begin
        if (fill > 0) begin
          fill--;
        end
      end
      mhpq_pkg::MODE_CHANGE: begin
      end
      mhpq_pkg::MODE_CLEAR: begin
        fill = 0;
      end
    endcase
    if (fill > peak_fill) begin
      peak_fill = fill;
    end
  endtask

  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start         <= 1'b0;
      in_mode       <= mhpq_pkg::mode_t'($urandom_range(0, 3));
      in_item_value <= $urandom();
      in_position   <= 10'($urandom_range(0, 1023));
    end
  endtask

  function automatic mhpq_pkg::mode_t pick_mode(input int w_ins, input int w_rem,
                                                input int w_chg, input int w_clr);
    int r;
    r = $urandom_range(0, w_ins + w_rem + w_chg + w_clr - 1);
    if (r < w_ins) begin
      return mhpq_pkg::MODE_INSERT;
    end else if (r < w_ins + w_rem) begin
      return mhpq_pkg::MODE_REMOVE;
    end else if (r < w_ins + w_rem + w_chg) begin
      return mhpq_pkg::MODE_CHANGE;
    end
    return mhpq_pkg::MODE_CLEAR;
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [9:0] pick_position();
    case ($urandom_range(0, 9))
      0:       return 10'($urandom_range(0, 1023));
      1:       return (fill > 1023) ? 10'd1023 : 10'(fill);
      default: return (fill > 0) ? 10'($urandom_range(0, fill - 1))
                                 : 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic random_request(input int w_ins, input int w_rem, input int w_chg,
                                input int w_clr);
    send_request(pick_mode(w_ins, w_rem, w_chg, w_clr), pick_key(), pick_position());
    if (idling_on && $urandom_range(0, 3) == 0) begin
      pause_sender($urandom_range(1, 10));
    end
  endtask

  initial begin : stimulus
    int waited;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_mode       <= mhpq_pkg::MODE_INSERT;
    in_item_value <= '0;
    in_position   <= '0;
    fill          = 0;
    peak_fill     = 0;
    requests      = 0;
    full_rejects  = 0;
    idling_on     = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(mhpq_pkg::MODE_REMOVE, 32'h1234_5678, 10'd0);
    send_request(mhpq_pkg::MODE_CHANGE, 32'hFFFF_FFFF, 10'd0);
    send_request(mhpq_pkg::MODE_CHANGE, 32'h0000_0000, 10'd1023);
    send_request(mhpq_pkg::MODE_CLEAR,  32'hA5A5_A5A5, 10'd0);
    send_request(mhpq_pkg::MODE_INSERT, 32'h0000_0000, 10'd0);
    send_request(mhpq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 10'd0);
    send_request(mhpq_pkg::MODE_INSERT, 32'h0000_0005, 10'd0);
    send_request(mhpq_pkg::MODE_INSERT, 32'h0000_0005, 10'd0);
    send_request(mhpq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 10'd0);
    send_request(mhpq_pkg::MODE_CHANGE, 32'h0000_0001, 10'd5);
    send_request(mhpq_pkg::MODE_CHANGE, 32'h0000_0001, 10'd1023);
    send_request(mhpq_pkg::MODE_CHANGE, 32'hFFFF_FFFE, 10'd3);
    send_request(mhpq_pkg::MODE_CHANGE, 32'h0000_0000, 10'd0);
    send_request(mhpq_pkg::MODE_CHANGE, 32'h0000_0007, 10'd4);
    send_request(mhpq_pkg::MODE_REMOVE, 32'h0000_0000, 10'd0);
    send_request(mhpq_pkg::MODE_REMOVE, 32'h0000_0000, 10'd0);
    send_request(mhpq_pkg::MODE_INSERT, 32'h8000_0000, 10'd0);
    send_request(mhpq_pkg::MODE_INSERT, 32'h7FFF_FFFF, 10'd0);
    send_request(mhpq_pkg::MODE_CLEAR,  32'h0000_0000, 10'd0);
    send_request(mhpq_pkg::MODE_REMOVE, 32'h0000_0000, 10'd0);
    send_request(mhpq_pkg::MODE_INSERT, 32'h0000_0001, 10'd0);
    send_request(mhpq_pkg::MODE_REMOVE, 32'h0000_0000, 10'd0);
    send_request(mhpq_pkg::MODE_CHANGE, 32'h0000_0003, 10'd0);

    repeat (250) random_request(45, 25, 27, 3);

    // Hold off new requests until every outstanding report has been checked.
    pause_sender(1);
    wait (pending == 0);

    while (fill < 256) random_request(92, 2, 6, 0);
    repeat (80) random_request(45, 15, 40, 0);

    idling_on = 1'b0;
    repeat (120) random_request(30, 40, 25, 5);
    send_request(mhpq_pkg::MODE_CLEAR, 32'h0000_0000, 10'd0);
    send_request(mhpq_pkg::MODE_REMOVE, 32'h0000_0000, 10'd0);
    pause_sender(1);

    waited = 0;
    while (pending != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);

    $display("Run covered %0d requests and %0d checked reports; peak fill %0d of %0d keys.",
             requests, checked, peak_fill, mhpq_pkg::HEAP_DEPTH);
    $display("Inserts refused at capacity: %0d; mismatches: %0d; reports outstanding: %0d.",
             full_rejects, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/max_heap_priority_queue.sv
tb/heap_result_checker.sv
tb/tb.sv
